// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the handle table.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ght_pkg.sv =====
// Types, codes and sizes of the generational handle table.
// No dependencies; used by ght_exec and generational_handle_table.
package ght_pkg;

    localparam int NUM_SLOTS = 1024;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int GEN_W     = 32;
    localparam int WORD_W    = 32;
    localparam int ST_W      = 3;

    localparam logic [2:0] ACT_CREATE      = 3'd0;
    localparam logic [2:0] ACT_DESTROY     = 3'd1;
    localparam logic [2:0] ACT_GET_META    = 3'd2;
    localparam logic [2:0] ACT_SET_STATE   = 3'd3;
    localparam logic [2:0] ACT_SET_PAYLOAD = 3'd4;
    localparam logic [2:0] ACT_IS_ALIVE    = 3'd5;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_MISMATCH  = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    typedef struct packed {
        logic              used;
        logic [GEN_W-1:0]  gen;
        logic [WORD_W-1:0] path_hash;
        logic [ST_W-1:0]   state;
        logic [WORD_W-1:0] type_id;
        logic [WORD_W-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic [2:0]        action;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_generation;
        logic [WORD_W-1:0] new_path_hash;
        logic [WORD_W-1:0] new_type_id;
        logic [ST_W-1:0]   expected_state;
        logic [ST_W-1:0]   next_state;
        logic [WORD_W-1:0] new_payload_slot;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  out_index;
        logic [GEN_W-1:0]  out_generation;
        logic              alive;
        logic [WORD_W-1:0] meta_path_hash;
        logic [ST_W-1:0]   meta_state;
        logic [WORD_W-1:0] meta_type_id;
        logic [WORD_W-1:0] meta_payload_slot;
        logic [CNT_W-1:0]  live_total;
        logic [CNT_W-1:0]  high_water;
    } t_result;

    // Bookkeeping the execute stage hands back to the sequencer.
    typedef struct packed {
        logic             slot_we;
        logic [IDX_W-1:0] slot_addr;
        t_slot            slot_wdata;
        logic             push_we;
        logic [IDX_W-1:0] push_addr;
        logic [IDX_W-1:0] push_data;
        logic [CNT_W-1:0] free_depth;
        logic [CNT_W-1:0] used_mark;
        logic [CNT_W-1:0] live;
        t_result          res;
    } t_exec;

endpackage

// ===== src/ght_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies; instanced for the slot table and the free stack.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ght_exec.sv =====
// Execute step: decides one action from the item, the slot read back and the counters.
// Depends on ght_pkg.
module ght_exec (
    input  ght_pkg::t_item                i_item,
    input  ght_pkg::t_slot                i_slot,
    input  logic [ght_pkg::IDX_W-1:0]     i_pop_idx,
    input  logic [ght_pkg::CNT_W-1:0]     i_free_depth,
    input  logic [ght_pkg::CNT_W-1:0]     i_used_mark,
    input  logic [ght_pkg::CNT_W-1:0]     i_live,
    output ght_pkg::t_exec                o_exec
);

    logic                          w_alive;
    logic [ght_pkg::IDX_W-1:0]     w_new_idx;
    logic [ght_pkg::GEN_W-1:0]     w_new_gen;
    logic                          w_got;

    assign w_alive = (i_item.handle_generation != '0)
                  && ({1'b0, i_item.handle_index} < i_used_mark)
                  && i_slot.used
                  && (i_slot.gen == i_item.handle_generation);

    always_comb begin
        w_got     = 1'b0;
        w_new_idx = i_pop_idx;
        w_new_gen = i_slot.gen;
        if (i_free_depth != '0) begin
            w_got = 1'b1;
        end else if (i_used_mark < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS)) begin
            w_got     = 1'b1;
            w_new_idx = i_used_mark[ght_pkg::IDX_W-1:0];
            w_new_gen = ght_pkg::GEN_W'(1);
        end
    end

    always_comb begin
        o_exec            = '0;
        o_exec.slot_addr  = i_item.handle_index;
        o_exec.slot_wdata = i_slot;
        o_exec.push_addr  = i_free_depth[ght_pkg::IDX_W-1:0];
        o_exec.push_data  = i_item.handle_index;
        o_exec.free_depth = i_free_depth;
        o_exec.used_mark  = i_used_mark;
        o_exec.live       = i_live;
        o_exec.res.status = ght_pkg::STS_NOT_FOUND;

        if (i_item.action == ght_pkg::ACT_CREATE) begin
            if (w_got) begin
                o_exec.slot_we    = 1'b1;
                o_exec.slot_addr  = w_new_idx;
                o_exec.slot_wdata = '{used: 1'b1, gen: w_new_gen,
                                      path_hash: i_item.new_path_hash, state: '0,
                                      type_id: i_item.new_type_id, payload: '0};
                if (i_free_depth != '0) begin
                    o_exec.free_depth = i_free_depth - ght_pkg::CNT_W'(1);
                end else begin
                    o_exec.used_mark = i_used_mark + ght_pkg::CNT_W'(1);
                end
                o_exec.live               = i_live + ght_pkg::CNT_W'(1);
                o_exec.res.status         = ght_pkg::STS_OK;
                o_exec.res.alive          = 1'b1;
                o_exec.res.out_index      = w_new_idx;
                o_exec.res.out_generation = w_new_gen;
            end else begin
                o_exec.res.status = ght_pkg::STS_FULL;
            end
        end else if (i_item.action <= ght_pkg::ACT_IS_ALIVE) begin
            o_exec.res.alive = w_alive;
            if (w_alive) begin
                o_exec.res.status = ght_pkg::STS_OK;
                case (i_item.action)
                    ght_pkg::ACT_DESTROY: begin
                        o_exec.slot_we    = 1'b1;
                        o_exec.slot_wdata = '{used: 1'b0,
                                              gen: i_slot.gen + ght_pkg::GEN_W'(1),
                                              path_hash: '0, state: '0,
                                              type_id: '0, payload: '0};
                        if (i_free_depth < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS)) begin
                            o_exec.push_we    = 1'b1;
                            o_exec.free_depth = i_free_depth + ght_pkg::CNT_W'(1);
                        end
                        o_exec.live = i_live - ght_pkg::CNT_W'(1);
                    end
                    ght_pkg::ACT_GET_META: begin
                        o_exec.res.meta_path_hash    = i_slot.path_hash;
                        o_exec.res.meta_state        = i_slot.state;
                        o_exec.res.meta_type_id      = i_slot.type_id;
                        o_exec.res.meta_payload_slot = i_slot.payload;
                    end
                    ght_pkg::ACT_SET_STATE: begin
                        if (i_slot.state != i_item.expected_state) begin
                            o_exec.res.status = ght_pkg::STS_MISMATCH;
                        end else begin
                            o_exec.slot_we          = 1'b1;
                            o_exec.slot_wdata.state = i_item.next_state;
                        end
                    end
                    ght_pkg::ACT_SET_PAYLOAD: begin
                        o_exec.slot_we            = 1'b1;
                        o_exec.slot_wdata.payload = i_item.new_payload_slot;
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_exec.res.live_total = o_exec.live;
        o_exec.res.high_water = o_exec.used_mark;
    end

endmodule

// ===== src/generational_handle_table.sv =====
// Generational handle table: the slot memory, free stack memory, sequencer and result register.
// Depends on ght_pkg, ght_ram, ght_exec and assert_macros.svh.
//
// A user sees one item at a time: o_in_ready is high only while the sequencer is idle.
// The slot memory is read at the accepting edge for every action other than create. A create
// that reuses a freed slot reads the free stack memory at the accepting edge and the slot
// memory in S_STACK, since the free stack memory is read before the slot memory. Every item
// then executes in S_EXEC, and writes back and loads the output register as it retires;
// the sequencer then returns to S_IDLE before it takes the next item. A new item is taken
// while an earlier result still waits on the output; the execute step holds only if that
// result has not yet been taken. No clearing pass: only slots below the high-water mark and
// stack entries below the stack depth are used.
`include "assert_macros.svh"

module generational_handle_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_action,
    input  logic [ght_pkg::IDX_W-1:0]      i_handle_index,
    input  logic [ght_pkg::GEN_W-1:0]      i_handle_generation,
    input  logic [ght_pkg::WORD_W-1:0]     i_new_path_hash,
    input  logic [ght_pkg::WORD_W-1:0]     i_new_type_id,
    input  logic [ght_pkg::ST_W-1:0]       i_expected_state,
    input  logic [ght_pkg::ST_W-1:0]       i_next_state,
    input  logic [ght_pkg::WORD_W-1:0]     i_new_payload_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [ght_pkg::IDX_W-1:0]      o_out_index,
    output logic [ght_pkg::GEN_W-1:0]      o_out_generation,
    output logic                           o_alive,
    output logic [ght_pkg::WORD_W-1:0]     o_meta_path_hash,
    output logic [ght_pkg::ST_W-1:0]       o_meta_state,
    output logic [ght_pkg::WORD_W-1:0]     o_meta_type_id,
    output logic [ght_pkg::WORD_W-1:0]     o_meta_payload_slot,
    output logic [ght_pkg::CNT_W-1:0]      o_live_total,
    output logic [ght_pkg::CNT_W-1:0]      o_high_water
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STACK = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    ght_pkg::t_item                r_item;
    logic [ght_pkg::CNT_W-1:0]     r_free_depth, r_used_mark, r_live;
    logic                          r_out_valid;
    ght_pkg::t_result              r_res;

    logic                          w_accept, w_is_create, w_retire;
    logic [ght_pkg::CNT_W-1:0]     w_depth_m1;
    logic                          w_slot_re;
    logic [ght_pkg::IDX_W-1:0]     w_slot_raddr;
    logic                          w_stack_re;
    ght_pkg::t_slot                w_slot_rdata;
    logic [ght_pkg::IDX_W-1:0]     w_stack_rdata;
    ght_pkg::t_exec                w_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_create = (i_action == ght_pkg::ACT_CREATE);
    assign w_depth_m1  = r_free_depth - ght_pkg::CNT_W'(1);
    // Execute retires once the result register is free or being emptied.
    assign w_retire    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_stack_re   = w_accept && w_is_create && (r_free_depth != '0);
    assign w_slot_re    = (w_accept && !w_is_create) || (r_state == S_STACK);
    assign w_slot_raddr = (r_state == S_STACK) ? w_stack_rdata : i_handle_index;

    ght_ram #(
        .WIDTH ($bits(ght_pkg::t_slot)),
        .DEPTH (ght_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_retire && w_exec.slot_we),
        .i_waddr (w_exec.slot_addr),
        .i_wdata (w_exec.slot_wdata),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    ght_ram #(
        .WIDTH (ght_pkg::IDX_W),
        .DEPTH (ght_pkg::NUM_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_retire && w_exec.push_we),
        .i_waddr (w_exec.push_addr),
        .i_wdata (w_exec.push_data),
        .i_re    (w_stack_re),
        .i_raddr (w_depth_m1[ght_pkg::IDX_W-1:0]),
        .o_rdata (w_stack_rdata)
    );

    ght_exec u_exec (
        .i_item       (r_item),
        .i_slot       (w_slot_rdata),
        .i_pop_idx    (w_stack_rdata),
        .i_free_depth (r_free_depth),
        .i_used_mark  (r_used_mark),
        .i_live       (r_live),
        .o_exec       (w_exec)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_stack_re ? S_STACK : S_EXEC;
                end
            end
            S_STACK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_retire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_depth <= '0;
            r_used_mark  <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_retire) begin
                r_free_depth <= w_exec.free_depth;
                r_used_mark  <= w_exec.used_mark;
                r_live       <= w_exec.live;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{action: i_action, handle_index: i_handle_index,
                        handle_generation: i_handle_generation,
                        new_path_hash: i_new_path_hash, new_type_id: i_new_type_id,
                        expected_state: i_expected_state, next_state: i_next_state,
                        new_payload_slot: i_new_payload_slot};
        end
        if (w_retire) begin
            r_res <= w_exec.res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_res.status;
    assign o_out_index         = r_res.out_index;
    assign o_out_generation    = r_res.out_generation;
    assign o_alive             = r_res.alive;
    assign o_meta_path_hash    = r_res.meta_path_hash;
    assign o_meta_state        = r_res.meta_state;
    assign o_meta_type_id      = r_res.meta_type_id;
    assign o_meta_payload_slot = r_res.meta_payload_slot;
    assign o_live_total        = r_res.live_total;
    assign o_high_water        = r_res.high_water;

    // Every slot below the high-water mark is either live or on the free stack.
    `GHT_ASSERT_NOW(a_slot_balance, 1'b1, (r_free_depth + r_live) == r_used_mark, "slot count balance broken")
    `GHT_ASSERT_NOW(a_live_le_hw, o_out_valid, o_live_total <= o_high_water, "live total above high water")
    `GHT_ASSERT_NEXT(a_one_at_a_time, w_accept, !o_in_ready, "item accepted while busy")
    `GHT_ASSERT_NOW(a_reuse_in_range, r_state == S_STACK, r_free_depth != '0, "stack pop with empty stack")

endmodule
